### rtl/core/htd_pkg.sv
// Shared types and constants for the Huffman tree decoder.
package htd_pkg;

  // Request kinds as sorted by the front part.
  typedef enum logic [2:0] {
    KIND_CLEAR,
    KIND_LOAD,
    KIND_BAD_LOAD,
    KIND_DECODE,
    KIND_STATUS
  } kind_e;

  // Command codes on the command port.
  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_LOAD   = 2'd1;
  localparam logic [1:0] CMD_DECODE = 2'd2;

  // Back part sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_STATUS,
    ST_DRD,
    ST_DBIT,
    ST_DCHK,
    ST_DFIN,
    ST_LSTEP,
    ST_LRD,
    ST_LWPAR
  } back_state_e;

  // One classified request as held in the queue.
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  symbol;
    logic [31:0] code_bits;
    logic [5:0]  code_len;
    logic [7:0]  data_byte;
  } req_t;

  // Queue head as seen by the back part.
  typedef struct packed {
    logic valid;
    req_t req;
  } head_t;

endpackage

### rtl/core/huffman_tree_decoder_top.sv
// Top level of the Huffman tree decoder: front queue plus tree walking back part.
// A clear or status request passes through the status state to the result register; a load
// walks and extends the tree one code bit at a time; a decode follows each data bit to a
// child, after fetching any saved walk position, and is set by the dependent node memory
// read at each bit before its results drain. A two-entry queue takes further requests while one is
// worked on; results cannot stall. Asynchronous active-low reset empties tree and flags.
module huffman_tree_decoder_top #(
  parameter int NODE_COUNT   = 512,
  parameter int MAX_CODE_LEN = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  command_i,
  input  logic [7:0]  symbol_i,
  input  logic [31:0] code_bits_i,
  input  logic [5:0]  code_len_i,
  input  logic [7:0]  data_byte_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i,
  output logic        res_strobe_o,
  output logic [7:0]  out_symbol_o,
  output logic        symbol_valid_o,
  output logic        done_res_o,
  output logic        fault_o,
  output logic        last_of_run_o
);

  htd_pkg::head_t head;
  logic           pop;

  assign cfg_ready_o = 1'b1;

  htd_front #(
    .MAX_CODE_LEN (MAX_CODE_LEN)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .command_i   (command_i),
    .symbol_i    (symbol_i),
    .code_bits_i (code_bits_i),
    .code_len_i  (code_len_i),
    .data_byte_i (data_byte_i),
    .busy_o      (busy),
    .head_o      (head),
    .pop_i       (pop)
  );

  htd_back #(
    .NODE_COUNT (NODE_COUNT)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head),
    .pop_o          (pop),
    .cfg_we_i       (cfg_valid_i && cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .res_strobe_o   (res_strobe_o),
    .out_symbol_o   (out_symbol_o),
    .symbol_valid_o (symbol_valid_o),
    .done_res_o     (done_res_o),
    .fault_o        (fault_o),
    .last_of_run_o  (last_of_run_o)
  );

endmodule

### rtl/core/htd_front.sv
// Front part: accepts requests, classifies them and queues them for the back part.
module htd_front #(
  parameter int MAX_CODE_LEN = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [1:0]        command_i,
  input  logic [7:0]        symbol_i,
  input  logic [31:0]       code_bits_i,
  input  logic [5:0]        code_len_i,
  input  logic [7:0]        data_byte_i,
  output logic              busy_o,
  output htd_pkg::head_t    head_o,
  input  logic              pop_i
);

  htd_pkg::req_t entry_q [2];
  logic          wr_ptr_q, wr_ptr_d;
  logic          rd_ptr_q, rd_ptr_d;
  logic [1:0]    cnt_q, cnt_d;
  htd_pkg::req_t req_new;
  logic          push;
  logic          pop;

  // Classify the incoming request; a code of bad length is flagged here.
  always_comb begin
    req_new.symbol    = symbol_i;
    req_new.code_bits = code_bits_i;
    req_new.code_len  = code_len_i;
    req_new.data_byte = data_byte_i;
    unique case (command_i)
      htd_pkg::CMD_CLEAR:  req_new.kind = htd_pkg::KIND_CLEAR;
      htd_pkg::CMD_LOAD: begin
        if (code_len_i == 6'd0 || 32'(code_len_i) > 32'(MAX_CODE_LEN)) begin
          req_new.kind = htd_pkg::KIND_BAD_LOAD;
        end else begin
          req_new.kind = htd_pkg::KIND_LOAD;
        end
      end
      htd_pkg::CMD_DECODE: req_new.kind = htd_pkg::KIND_DECODE;
      default:             req_new.kind = htd_pkg::KIND_STATUS;
    endcase
  end

  assign busy_o = (cnt_q == 2'd2);
  assign push   = start_i && !busy_o;
  assign pop    = pop_i && (cnt_q != 2'd0);

  assign head_o.valid = (cnt_q != 2'd0);
  assign head_o.req   = entry_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= req_new;
    end
  end

endmodule

### rtl/core/htd_back.sv
// Back part: owns the node memory, inserts codes and walks compressed bytes.
module htd_back #(
  parameter int NODE_COUNT = 512
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  htd_pkg::head_t    head_i,
  output logic              pop_o,
  input  logic              cfg_we_i,
  input  logic [7:0]        cfg_data_i,
  output logic              res_strobe_o,
  output logic [7:0]        out_symbol_o,
  output logic              symbol_valid_o,
  output logic              done_res_o,
  output logic              fault_o,
  output logic              last_of_run_o
);

  localparam int IW  = $clog2(NODE_COUNT);
  localparam int NFW = $clog2(NODE_COUNT + 1);
  localparam int RW  = 2 + 2 * IW + 8;

  // Node memory: {left valid, right valid, left index, right index, symbol}.
  logic [RW-1:0] mem [NODE_COUNT];
  logic          mem_we;
  logic [IW-1:0] mem_waddr, mem_raddr;
  logic [RW-1:0] mem_wdata, rdata_q;

  logic          rd_l_ok, rd_r_ok;
  logic [IW-1:0] rd_l, rd_r;
  logic [7:0]    rd_sym;

  htd_pkg::back_state_e state_q, state_d;

  logic          root_l_ok_q, root_l_ok_d, root_r_ok_q, root_r_ok_d;
  logic [IW-1:0] root_l_q, root_l_d, root_r_q, root_r_d;
  logic          cur_l_ok_q, cur_l_ok_d, cur_r_ok_q, cur_r_ok_d;
  logic [IW-1:0] cur_l_q, cur_l_d, cur_r_q, cur_r_d;
  logic [IW-1:0] cur_idx_q, cur_idx_d, nxt_idx_q, nxt_idx_d;
  logic [IW-1:0] walk_q, walk_d;
  logic [NFW-1:0] nf_q, nf_d;
  logic          eof_q, eof_d, fault_q, fault_d;
  logic [7:0]    eof_sym_q;

  logic [7:0]    sym_q, sym_d, byte_q, byte_d;
  logic [31:0]   bits_q, bits_d;
  logic [5:0]    rem_q, rem_d;
  logic [2:0]    bitcnt_q, bitcnt_d;
  logic          pend_q, pend_d, stat_q, stat_d;
  logic [7:0]    pend_sym_q, pend_sym_d;

  logic          emit, emit_valid, emit_last;
  logic [7:0]    emit_sym;
  logic          res_strobe_q;
  logic [7:0]    res_sym_q;
  logic          res_valid_q, res_done_q, res_fault_q, res_last_q;

  logic [5:0]    pos;
  logic          lbit, dbit, child_ok, overflow;
  logic [IW-1:0] child_idx;

  assign {rd_l_ok, rd_r_ok, rd_l, rd_r, rd_sym} = rdata_q;

  assign pos       = rem_q - 6'd1;
  assign lbit      = (pos < 6'd32) ? bits_q[pos[4:0]] : 1'b0;
  assign dbit      = byte_q[bitcnt_q];
  assign overflow  = (nf_q == NFW'(NODE_COUNT));

  // Next state and datapath control.
  always_comb begin
    state_d     = state_q;
    root_l_ok_d = root_l_ok_q;
    root_r_ok_d = root_r_ok_q;
    root_l_d    = root_l_q;
    root_r_d    = root_r_q;
    cur_l_ok_d  = cur_l_ok_q;
    cur_r_ok_d  = cur_r_ok_q;
    cur_l_d     = cur_l_q;
    cur_r_d     = cur_r_q;
    cur_idx_d   = cur_idx_q;
    nxt_idx_d   = nxt_idx_q;
    walk_d      = walk_q;
    nf_d        = nf_q;
    eof_d       = eof_q;
    fault_d     = fault_q;
    sym_d       = sym_q;
    byte_d      = byte_q;
    bits_d      = bits_q;
    rem_d       = rem_q;
    bitcnt_d    = bitcnt_q;
    pend_d      = pend_q;
    pend_sym_d  = pend_sym_q;
    stat_d      = stat_q;
    pop_o       = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = nf_q[IW-1:0];
    mem_wdata   = '0;
    mem_raddr   = walk_q;
    emit        = 1'b0;
    emit_valid  = 1'b0;
    emit_last   = 1'b0;
    emit_sym    = 8'd0;
    child_ok    = 1'b0;
    child_idx   = '0;

    unique case (state_q)
      htd_pkg::ST_IDLE: begin
        if (head_i.valid) begin
          pop_o    = 1'b1;
          sym_d    = head_i.req.symbol;
          bits_d   = head_i.req.code_bits;
          rem_d    = head_i.req.code_len;
          byte_d   = head_i.req.data_byte;
          bitcnt_d = 3'd7;
          pend_d   = 1'b0;
          stat_d   = 1'b0;
          unique case (head_i.req.kind)
            htd_pkg::KIND_CLEAR: begin
              root_l_ok_d = 1'b0;
              root_r_ok_d = 1'b0;
              root_l_d    = '0;
              root_r_d    = '0;
              nf_d        = NFW'(1);
              walk_d      = '0;
              eof_d       = 1'b0;
              fault_d     = 1'b0;
              state_d     = htd_pkg::ST_STATUS;
            end
            htd_pkg::KIND_BAD_LOAD: begin
              fault_d = 1'b1;
              state_d = htd_pkg::ST_STATUS;
            end
            htd_pkg::KIND_LOAD: begin
              cur_l_ok_d = root_l_ok_q;
              cur_r_ok_d = root_r_ok_q;
              cur_l_d    = root_l_q;
              cur_r_d    = root_r_q;
              cur_idx_d  = '0;
              state_d    = htd_pkg::ST_LSTEP;
            end
            htd_pkg::KIND_DECODE: begin
              if (eof_q || fault_q) begin
                state_d = htd_pkg::ST_STATUS;
              end else if (walk_q == '0) begin
                cur_l_ok_d = root_l_ok_q;
                cur_r_ok_d = root_r_ok_q;
                cur_l_d    = root_l_q;
                cur_r_d    = root_r_q;
                state_d    = htd_pkg::ST_DBIT;
              end else begin
                mem_raddr = walk_q;
                state_d   = htd_pkg::ST_DRD;
              end
            end
            default: state_d = htd_pkg::ST_STATUS;
          endcase
        end
      end

      // A single status result closes the run.
      htd_pkg::ST_STATUS: begin
        emit      = 1'b1;
        emit_last = 1'b1;
        state_d   = htd_pkg::ST_IDLE;
      end

      // Saved walk position fetched from memory.
      htd_pkg::ST_DRD: begin
        cur_l_ok_d = rd_l_ok;
        cur_r_ok_d = rd_r_ok;
        cur_l_d    = rd_l;
        cur_r_d    = rd_r;
        state_d    = htd_pkg::ST_DBIT;
      end

      // Follow one data bit to a child and fetch that child.
      htd_pkg::ST_DBIT: begin
        child_ok  = dbit ? cur_r_ok_q : cur_l_ok_q;
        child_idx = dbit ? cur_r_q : cur_l_q;
        if (!child_ok) begin
          fault_d = 1'b1;
          walk_d  = '0;
          stat_d  = 1'b1;
          state_d = htd_pkg::ST_DFIN;
        end else begin
          mem_raddr = child_idx;
          walk_d    = child_idx;
          state_d   = htd_pkg::ST_DCHK;
        end
      end

      // Inspect the fetched child: a leaf other than the end symbol yields a symbol; every leaf returns to the root.
      htd_pkg::ST_DCHK: begin
        if (!rd_l_ok && !rd_r_ok) begin
          walk_d     = '0;
          cur_l_ok_d = root_l_ok_q;
          cur_r_ok_d = root_r_ok_q;
          cur_l_d    = root_l_q;
          cur_r_d    = root_r_q;
        end else begin
          cur_l_ok_d = rd_l_ok;
          cur_r_ok_d = rd_r_ok;
          cur_l_d    = rd_l;
          cur_r_d    = rd_r;
        end
        if (!rd_l_ok && !rd_r_ok && rd_sym == eof_sym_q) begin
          eof_d   = 1'b1;
          stat_d  = 1'b1;
          state_d = htd_pkg::ST_DFIN;
        end else begin
          if (!rd_l_ok && !rd_r_ok) begin
            // Release the previous symbol; it is not the last of the run.
            emit       = pend_q;
            emit_valid = 1'b1;
            emit_sym   = pend_sym_q;
            pend_d     = 1'b1;
            pend_sym_d = rd_sym;
          end
          if (bitcnt_q == 3'd0) begin
            state_d = htd_pkg::ST_DFIN;
          end else begin
            bitcnt_d = bitcnt_q - 3'd1;
            state_d  = htd_pkg::ST_DBIT;
          end
        end
      end

      // Drain the held symbol; add a status result where one is due or no symbol is held.
      htd_pkg::ST_DFIN: begin
        emit = 1'b1;
        if (pend_q) begin
          emit_valid = 1'b1;
          emit_sym   = pend_sym_q;
          pend_d     = 1'b0;
          if (stat_q) begin
            state_d = htd_pkg::ST_DFIN;
          end else begin
            emit_last = 1'b1;
            state_d   = htd_pkg::ST_IDLE;
          end
        end else begin
          emit_last = 1'b1;
          state_d   = htd_pkg::ST_IDLE;
        end
      end

      // One code bit: descend into an existing child or allocate a node, or fault when memory is full.
      htd_pkg::ST_LSTEP: begin
        child_ok  = lbit ? cur_r_ok_q : cur_l_ok_q;
        child_idx = lbit ? cur_r_q : cur_l_q;
        if (rem_q == 6'd1 || !child_ok) begin
          if (overflow) begin
            fault_d = 1'b1;
            state_d = htd_pkg::ST_STATUS;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = nf_q[IW-1:0];
            mem_wdata = {2'b00, {(2 * IW){1'b0}}, (rem_q == 6'd1) ? sym_q : 8'd0};
            if (lbit) begin
              cur_r_ok_d = 1'b1;
              cur_r_d    = nf_q[IW-1:0];
            end else begin
              cur_l_ok_d = 1'b1;
              cur_l_d    = nf_q[IW-1:0];
            end
            nxt_idx_d = nf_q[IW-1:0];
            nf_d      = nf_q + NFW'(1);
            state_d   = htd_pkg::ST_LWPAR;
          end
        end else begin
          mem_raddr = child_idx;
          cur_idx_d = child_idx;
          rem_d     = rem_q - 6'd1;
          state_d   = htd_pkg::ST_LRD;
        end
      end

      htd_pkg::ST_LRD: begin
        cur_l_ok_d = rd_l_ok;
        cur_r_ok_d = rd_r_ok;
        cur_l_d    = rd_l;
        cur_r_d    = rd_r;
        state_d    = htd_pkg::ST_LSTEP;
      end

      // Write back the parent with its new child; the root lives in registers.
      htd_pkg::ST_LWPAR: begin
        if (cur_idx_q == '0) begin
          root_l_ok_d = cur_l_ok_q;
          root_r_ok_d = cur_r_ok_q;
          root_l_d    = cur_l_q;
          root_r_d    = cur_r_q;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = cur_idx_q;
          mem_wdata = {cur_l_ok_q, cur_r_ok_q, cur_l_q, cur_r_q, 8'd0};
        end
        if (rem_q == 6'd1) begin
          state_d = htd_pkg::ST_STATUS;
        end else begin
          cur_l_ok_d = 1'b0;
          cur_r_ok_d = 1'b0;
          cur_l_d    = '0;
          cur_r_d    = '0;
          cur_idx_d  = nxt_idx_q;
          rem_d      = rem_q - 6'd1;
          state_d    = htd_pkg::ST_LSTEP;
        end
      end

      default: state_d = htd_pkg::ST_IDLE;
    endcase
  end

  // Node memory with registered read.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= htd_pkg::ST_IDLE;
      root_l_ok_q <= 1'b0;
      root_r_ok_q <= 1'b0;
      root_l_q    <= '0;
      root_r_q    <= '0;
      walk_q      <= '0;
      nf_q        <= NFW'(1);
      eof_q       <= 1'b0;
      fault_q     <= 1'b0;
      eof_sym_q   <= 8'd0;
      pend_q      <= 1'b0;
      stat_q      <= 1'b0;
      res_strobe_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      root_l_ok_q <= root_l_ok_d;
      root_r_ok_q <= root_r_ok_d;
      root_l_q    <= root_l_d;
      root_r_q    <= root_r_d;
      walk_q      <= walk_d;
      nf_q        <= nf_d;
      eof_q       <= eof_d;
      fault_q     <= fault_d;
      pend_q      <= pend_d;
      stat_q      <= stat_d;
      res_strobe_q <= emit;
      if (cfg_we_i) begin
        eof_sym_q <= cfg_data_i;
      end
    end
  end

  // Working registers and result register; symbol results carry clear flags,
  // since both flags are forced to zero whenever a symbol is emitted.
  always_ff @(posedge clk_i) begin
    cur_l_ok_q <= cur_l_ok_d;
    cur_r_ok_q <= cur_r_ok_d;
    cur_l_q    <= cur_l_d;
    cur_r_q    <= cur_r_d;
    cur_idx_q  <= cur_idx_d;
    nxt_idx_q  <= nxt_idx_d;
    sym_q      <= sym_d;
    byte_q     <= byte_d;
    bits_q     <= bits_d;
    rem_q      <= rem_d;
    bitcnt_q   <= bitcnt_d;
    pend_sym_q <= pend_sym_d;
    res_sym_q  <= emit_valid ? emit_sym : 8'd0;
    res_valid_q <= emit_valid;
    res_done_q  <= emit_valid ? 1'b0 : eof_q;
    res_fault_q <= emit_valid ? 1'b0 : fault_q;
    res_last_q  <= emit_last;
  end

  assign res_strobe_o   = res_strobe_q;
  assign out_symbol_o   = res_sym_q;
  assign symbol_valid_o = res_valid_q;
  assign done_res_o     = res_done_q;
  assign fault_o        = res_fault_q;
  assign last_of_run_o  = res_last_q;

endmodule

### rtl/core/htd_checker.sv
// Port level checks for the Huffman tree decoder and their binding.
module htd_port_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       res_strobe_o,
  input logic [7:0] out_symbol_o,
  input logic       symbol_valid_o,
  input logic       done_res_o,
  input logic       fault_o,
  input logic       last_of_run_o
);

  // A decoded symbol result never carries a raised flag.
  a_sym_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o && symbol_valid_o |-> !done_res_o && !fault_o)
    else $error("symbol result with a flag raised");

  // A status result carries a zero symbol.
  a_status_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o && !symbol_valid_o |-> out_symbol_o == 8'd0)
    else $error("status result with non-zero symbol");

  // A status result always closes its run.
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o && !symbol_valid_o |-> last_of_run_o)
    else $error("status result not last of run");

endmodule

bind huffman_tree_decoder_top htd_port_checker u_htd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .res_strobe_o   (res_strobe_o),
  .out_symbol_o   (out_symbol_o),
  .symbol_valid_o (symbol_valid_o),
  .done_res_o     (done_res_o),
  .fault_o        (fault_o),
  .last_of_run_o  (last_of_run_o)
);
